>>> sv/lwkr_pkg.sv
package lwkr_pkg;

    // Default sizes, handed to the top level parameters
    localparam int unsigned MAX_LEN_DEF  = 4096;
    localparam int unsigned ALPHABET_DEF = 256;

    // Fixed field widths of the channels and the configuration register
    localparam int unsigned SYM_W   = 8;
    localparam int unsigned FIELD_W = 13;

    // Counters held side by side in one row of the count memory
    localparam int unsigned LANES  = 16;
    localparam int unsigned LANE_W = 4;

    typedef logic [SYM_W-1:0] sym_table_t [2**SYM_W];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INC,
        ST_DEC_RD,
        ST_DEC,
        ST_SCAN,
        ST_SCAN_END,
        ST_EMIT
    } lwkr_state_t;

    // Control word from the sequencer to the count memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear_all;
    } lwkr_cnt_ctl_t;

    // Fold a raw byte into the alphabet by counting up and wrapping
    function automatic sym_table_t build_mod_table(input int unsigned alphabet);
        sym_table_t  t;
        int unsigned c;
        int unsigned i;
        c = 0;
        for (i = 0; i < 2**SYM_W; i++)
        begin
            t[i] = SYM_W'(c);
            if (c + 1 == alphabet)
                c = 0;
            else
                c = c + 1;
        end
        return t;
    endfunction

endpackage

>>> sv/lwkr_in_if.sv
interface lwkr_in_if;
    import lwkr_pkg::*;

    logic               valid;
    logic               ready;
    logic [SYM_W-1:0]   symbol;
    logic               last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

>>> sv/lwkr_out_if.sv
interface lwkr_out_if;
    import lwkr_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] best_length;
    logic               end_of_string;
    logic               too_long;

    modport source (output valid, output best_length, output end_of_string,
                    output too_long, input ready);
    modport sink   (input valid, input best_length, input end_of_string,
                    input too_long, output ready);
endinterface

>>> sv/longest_window_k_replacements_top.sv
// Channel   Dir  Payload                                   Handshake
// in_ch     in   symbol[7:0], last_symbol                  valid/ready
// out_ch    out  best_length[12:0], end_of_string, too_long valid/ready
// cfg       in   cfg_data[12:0] -> allowed_changes         cfg_write, no stall
//
// A word passes ST_INC and ST_EMIT after acceptance before ready returns when
// the window grows, and also ST_DEC_RD, ST_DEC, the scan of all ROWS rows and
// ST_SCAN_END when it shrinks: the rescan reads one row of 16 counters a cycle.
// Reset is asynchronous and needs no clearing pass; counter rows carry marks.
// A finished word waits in the output register while the next one is taken;
// the sequencer holds only while that register is still full.
module longest_window_k_replacements_top #(
    parameter int unsigned MAX_LEN  = lwkr_pkg::MAX_LEN_DEF,
    parameter int unsigned ALPHABET = lwkr_pkg::ALPHABET_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [lwkr_pkg::FIELD_W-1:0]   cfg_data,
    lwkr_in_if.sink                        in_ch,
    lwkr_out_if.source                     out_ch
);
    import lwkr_pkg::*;

    localparam int unsigned ROWS   = (ALPHABET + LANES - 1) / LANES;
    localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
    localparam int unsigned ADDR_W = $clog2(MAX_LEN);

    logic [FIELD_W-1:0]      allowed_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]      out_best_reg;
    logic                    out_eos_reg;
    logic                    out_long_reg;

    logic                    slot_free;
    logic                    res_load;
    logic [FIELD_W-1:0]      res_best;
    logic                    res_eos;
    logic                    res_too_long;

    lwkr_cnt_ctl_t           cnt_ctl;
    logic [ROW_W-1:0]        cnt_rd_row;
    logic [ROW_W-1:0]        cnt_wr_row;
    logic [LANES*CNT_W-1:0]  cnt_wr_data;
    logic [LANES*CNT_W-1:0]  cnt_rd_data;

    logic                    ring_wr_en;
    logic [ADDR_W-1:0]       ring_wr_addr;
    logic [SYM_W-1:0]        ring_wr_data;
    logic                    ring_rd_en;
    logic [ADDR_W-1:0]       ring_rd_addr;
    logic [SYM_W-1:0]        ring_rd_data;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            allowed_reg <= '0;
        else if (cfg_write)
            allowed_reg <= cfg_data;
    end

    lwkr_seq #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET),
        .ROW_W    (ROW_W),
        .CNT_W    (CNT_W),
        .ADDR_W   (ADDR_W)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (in_ch.valid),
        .ready           (in_ch.ready),
        .symbol          (in_ch.symbol),
        .last_symbol     (in_ch.last_symbol),
        .allowed_changes (allowed_reg),
        .slot_free       (slot_free),
        .res_load        (res_load),
        .res_best        (res_best),
        .res_eos         (res_eos),
        .res_too_long    (res_too_long),
        .cnt_ctl         (cnt_ctl),
        .cnt_rd_row      (cnt_rd_row),
        .cnt_wr_row      (cnt_wr_row),
        .cnt_wr_data     (cnt_wr_data),
        .cnt_rd_data     (cnt_rd_data),
        .ring_wr_en      (ring_wr_en),
        .ring_wr_addr    (ring_wr_addr),
        .ring_wr_data    (ring_wr_data),
        .ring_rd_en      (ring_rd_en),
        .ring_rd_addr    (ring_rd_addr),
        .ring_rd_data    (ring_rd_data)
    );

    lwkr_count_mem #(
        .ROW_W (ROW_W),
        .CNT_W (CNT_W)
    ) u_count_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (cnt_ctl),
        .rd_row  (cnt_rd_row),
        .wr_row  (cnt_wr_row),
        .wr_data (cnt_wr_data),
        .rd_data (cnt_rd_data)
    );

    lwkr_ring_mem #(
        .ADDR_W (ADDR_W)
    ) u_ring_mem (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_wr_addr),
        .wr_data (ring_wr_data),
        .rd_en   (ring_rd_en),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd_data)
    );

    // Output register: load a finished word, drop it once taken
    assign slot_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_best_reg <= res_best;
            out_eos_reg  <= res_eos;
            out_long_reg <= res_too_long;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.best_length   = out_best_reg;
    assign out_ch.end_of_string = out_eos_reg;
    assign out_ch.too_long      = out_long_reg;

endmodule

>>> sv/lwkr_count_mem.sv
module lwkr_count_mem #(
    parameter int unsigned ROW_W = 4,
    parameter int unsigned CNT_W = 13
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lwkr_pkg::lwkr_cnt_ctl_t               ctl,
    input  logic [ROW_W-1:0]                      rd_row,
    input  logic [ROW_W-1:0]                      wr_row,
    input  logic [lwkr_pkg::LANES*CNT_W-1:0]      wr_data,
    output logic [lwkr_pkg::LANES*CNT_W-1:0]      rd_data
);
    import lwkr_pkg::*;

    localparam int unsigned DEPTH = 2**ROW_W;
    localparam int unsigned ROW_BITS = LANES * CNT_W;

    logic [ROW_BITS-1:0] counts_mem [DEPTH];
    logic [ROW_BITS-1:0] rd_raw_reg;
    logic                rd_hit_reg;
    logic [DEPTH-1:0]    valid_reg;
    logic [DEPTH-1:0]    valid_next;

    // Row storage: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            counts_mem[wr_row] <= wr_data;
        if (ctl.rd_en)
            rd_raw_reg <= counts_mem[rd_row];
    end

    // Mark written rows; drop every mark at end of string
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clear_all)
            valid_next = '0;
        else if (ctl.wr_en)
            valid_next[wr_row] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctl.rd_en)
                rd_hit_reg <= valid_reg[rd_row];
        end
    end

    // A row never written since the last clear reads as zero
    assign rd_data = rd_hit_reg ? rd_raw_reg : '0;

endmodule

>>> sv/lwkr_ring_mem.sv
module lwkr_ring_mem #(
    parameter int unsigned ADDR_W = 12
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [lwkr_pkg::SYM_W-1:0]   wr_data,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [lwkr_pkg::SYM_W-1:0]   rd_data
);
    import lwkr_pkg::*;

    logic [SYM_W-1:0] ring_mem [2**ADDR_W];
    logic [SYM_W-1:0] rd_data_reg;

    // Symbols by string position; read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= ring_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/lwkr_seq.sv
module lwkr_seq #(
    parameter int unsigned MAX_LEN  = 4096,
    parameter int unsigned ALPHABET = 256,
    parameter int unsigned ROW_W    = 4,
    parameter int unsigned CNT_W    = 13,
    parameter int unsigned ADDR_W   = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // incoming word
    input  logic                               start,
    output logic                               ready,
    input  logic [lwkr_pkg::SYM_W-1:0]         symbol,
    input  logic                               last_symbol,
    input  logic [lwkr_pkg::FIELD_W-1:0]       allowed_changes,
    // result hand-off to the output register
    input  logic                               slot_free,
    output logic                               res_load,
    output logic [lwkr_pkg::FIELD_W-1:0]       res_best,
    output logic                               res_eos,
    output logic                               res_too_long,
    // count memory
    output lwkr_pkg::lwkr_cnt_ctl_t            cnt_ctl,
    output logic [ROW_W-1:0]                   cnt_rd_row,
    output logic [ROW_W-1:0]                   cnt_wr_row,
    output logic [lwkr_pkg::LANES*CNT_W-1:0]   cnt_wr_data,
    input  logic [lwkr_pkg::LANES*CNT_W-1:0]   cnt_rd_data,
    // window ring
    output logic                               ring_wr_en,
    output logic [ADDR_W-1:0]                  ring_wr_addr,
    output logic [lwkr_pkg::SYM_W-1:0]         ring_wr_data,
    output logic                               ring_rd_en,
    output logic [ADDR_W-1:0]                  ring_rd_addr,
    input  logic [lwkr_pkg::SYM_W-1:0]         ring_rd_data
);
    import lwkr_pkg::*;

    localparam int unsigned ROWS  = (ALPHABET + LANES - 1) / LANES;
    localparam int unsigned SUM_W = ((CNT_W > FIELD_W) ? CNT_W : FIELD_W) + 1;
    localparam sym_table_t  MOD_TABLE = build_mod_table(ALPHABET);

    lwkr_state_t        state_reg, state_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic               last_reg, last_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic [CNT_W-1:0]   right_reg, right_next;
    logic [CNT_W-1:0]   top_reg, top_next;
    logic [CNT_W-1:0]   best_reg, best_next;
    logic               ovf_reg, ovf_next;
    logic [ROW_W-1:0]   scan_row_reg, scan_row_next;
    logic [CNT_W-1:0]   scan_max_reg, scan_max_next;
    logic               fold_reg, fold_next;

    logic [SYM_W-1:0]        in_sym;
    logic [LANE_W-1:0]       lane;
    logic [CNT_W-1:0]        cur_cnt;
    logic [CNT_W-1:0]        new_cnt;
    logic [CNT_W-1:0]        top_new;
    logic [CNT_W-1:0]        win_len;
    logic                    shrink;
    logic [LANES*CNT_W-1:0]  row_mod;
    logic [CNT_W-1:0]        lvl8 [8];
    logic [CNT_W-1:0]        lvl4 [4];
    logic [CNT_W-1:0]        lvl2 [2];
    logic [CNT_W-1:0]        row_max;

    assign in_sym = MOD_TABLE[symbol];

    // Highest counter of the row just read: four compare levels
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            lvl8[i] = (cnt_rd_data[(2*i)*CNT_W +: CNT_W] > cnt_rd_data[(2*i+1)*CNT_W +: CNT_W])
                    ? cnt_rd_data[(2*i)*CNT_W +: CNT_W]
                    : cnt_rd_data[(2*i+1)*CNT_W +: CNT_W];
        end
        for (int i = 0; i < 4; i++)
            lvl4[i] = (lvl8[2*i] > lvl8[2*i+1]) ? lvl8[2*i] : lvl8[2*i+1];
        for (int i = 0; i < 2; i++)
            lvl2[i] = (lvl4[2*i] > lvl4[2*i+1]) ? lvl4[2*i] : lvl4[2*i+1];
        row_max = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
    end

    // Counter of the lane under update, bumped or lowered
    always_comb
    begin
        lane = (state_reg == ST_DEC) ? ring_rd_data[LANE_W-1:0] : sym_reg[LANE_W-1:0];
        cur_cnt = cnt_rd_data[lane*CNT_W +: CNT_W];
        if (state_reg == ST_DEC)
            new_cnt = (cur_cnt != '0) ? cur_cnt - CNT_W'(1) : cur_cnt;
        else
            new_cnt = cur_cnt + CNT_W'(1);
        row_mod = cnt_rd_data;
        row_mod[lane*CNT_W +: CNT_W] = new_cnt;
        top_new = (new_cnt > top_reg) ? new_cnt : top_reg;
        win_len = right_reg - left_reg + CNT_W'(1);
        shrink  = SUM_W'(win_len) > (SUM_W'(top_new) + SUM_W'(allowed_changes));
    end

    // Next state and memory requests
    always_comb
    begin
        state_next    = state_reg;
        sym_next      = sym_reg;
        last_next     = last_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        top_next      = top_reg;
        best_next     = best_reg;
        ovf_next      = ovf_reg;
        scan_row_next = scan_row_reg;
        scan_max_next = scan_max_reg;
        fold_next     = fold_reg;

        ready         = 1'b0;
        res_load      = 1'b0;
        cnt_ctl       = '0;
        cnt_rd_row    = '0;
        cnt_wr_row    = ROW_W'(sym_reg >> LANE_W);
        cnt_wr_data   = row_mod;
        ring_wr_en    = 1'b0;
        ring_wr_addr  = right_reg[ADDR_W-1:0];
        ring_wr_data  = in_sym;
        ring_rd_en    = 1'b0;
        ring_rd_addr  = left_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
                if (start)
                begin
                    last_next = last_symbol;
                    if (right_reg >= CNT_W'(MAX_LEN))
                    begin
                        // string full: drop the symbol, flag it
                        ovf_next   = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        sym_next       = in_sym;
                        cnt_ctl.rd_en  = 1'b1;
                        cnt_rd_row     = ROW_W'(in_sym >> LANE_W);
                        ring_wr_en     = 1'b1;
                        ring_rd_en     = 1'b1;
                        state_next     = ST_INC;
                    end
                end
            end

            ST_INC:
            begin
                // append on the right, then test the window
                cnt_ctl.wr_en = 1'b1;
                top_next      = top_new;
                right_next    = right_reg + CNT_W'(1);
                if (shrink)
                    state_next = ST_DEC_RD;
                else
                begin
                    if (win_len > best_reg)
                        best_next = win_len;
                    state_next = ST_EMIT;
                end
            end

            ST_DEC_RD:
            begin
                cnt_ctl.rd_en = 1'b1;
                cnt_rd_row    = ROW_W'(ring_rd_data >> LANE_W);
                state_next    = ST_DEC;
            end

            ST_DEC:
            begin
                // drop the left symbol's count
                cnt_ctl.wr_en = 1'b1;
                cnt_wr_row    = ROW_W'(ring_rd_data >> LANE_W);
                scan_row_next = '0;
                scan_max_next = '0;
                fold_next     = 1'b0;
                state_next    = ST_SCAN;
            end

            ST_SCAN:
            begin
                // read one row a cycle, fold the previous one
                cnt_ctl.rd_en = 1'b1;
                cnt_rd_row    = scan_row_reg;
                fold_next     = 1'b1;
                if (fold_reg && (row_max > scan_max_reg))
                    scan_max_next = row_max;
                scan_row_next = scan_row_reg + ROW_W'(1);
                if (scan_row_reg == ROW_W'(ROWS - 1))
                    state_next = ST_SCAN_END;
            end

            ST_SCAN_END:
            begin
                top_next   = (row_max > scan_max_reg) ? row_max : scan_max_reg;
                left_next  = left_reg + CNT_W'(1);
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (last_reg)
                    begin
                        // end of string: clear the window
                        cnt_ctl.clear_all = 1'b1;
                        left_next  = '0;
                        right_next = '0;
                        top_next   = '0;
                        best_next  = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_best     = FIELD_W'(best_reg);
    assign res_eos      = last_reg;
    assign res_too_long = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            last_reg     <= 1'b0;
            left_reg     <= '0;
            right_reg    <= '0;
            top_reg      <= '0;
            best_reg     <= '0;
            ovf_reg      <= 1'b0;
            scan_row_reg <= '0;
            scan_max_reg <= '0;
            fold_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            last_reg     <= last_next;
            left_reg     <= left_next;
            right_reg    <= right_next;
            top_reg      <= top_next;
            best_reg     <= best_next;
            ovf_reg      <= ovf_next;
            scan_row_reg <= scan_row_next;
            scan_max_reg <= scan_max_next;
            fold_reg     <= fold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
    end

    // Window bounds stay ordered and inside the string
    a_left_le_right: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= right_reg)
        else $error("left bound passed right bound");

    a_right_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        right_reg <= CNT_W'(MAX_LEN))
        else $error("right bound beyond string limit");

    a_best_le_right: assert property (@(posedge clk) disable iff (!rst_n)
        best_reg <= right_reg)
        else $error("best length longer than the string");

    // The count memory never reads and writes in one cycle
    a_cnt_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cnt_ctl.rd_en && cnt_ctl.wr_en))
        else $error("count memory read and write overlap");

    a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && last_reg) |=> (right_reg == '0 && best_reg == '0 && !ovf_reg))
        else $error("string state not cleared after last word");

endmodule

>>> sim/lwkr_checker.sv
module lwkr_checker #(
    parameter int unsigned MAX_LEN  = lwkr_pkg::MAX_LEN_DEF,
    parameter int unsigned ALPHABET = lwkr_pkg::ALPHABET_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [lwkr_pkg::FIELD_W-1:0] cfg_data,
    lwkr_in_if                           in_ch,
    lwkr_out_if                          out_ch,
    output int                           failures,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lwkr_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0] best_length;
        logic               end_of_string;
        logic               too_long;
    } window_result_t;

    // Own copy of the window state and the replacement budget
    logic [FIELD_W-1:0] replace_budget = '0;
    int unsigned        symbol_tally [ALPHABET];
    logic [SYM_W-1:0]   string_ring [MAX_LEN];
    int unsigned        left_edge = 0;
    int unsigned        right_edge = 0;
    int unsigned        peak_count = 0;
    int unsigned        best_span = 0;
    logic               overflow_flag = 1'b0;

    window_result_t     awaited_q [$];
    int                 error_total = 0;

    assign failures = error_total;

    // Drop everything that belongs to the current string
    function automatic void clear_window();
        foreach (symbol_tally[i])
            symbol_tally[i] = 0;
        left_edge     = 0;
        right_edge    = 0;
        peak_count    = 0;
        best_span     = 0;
        overflow_flag = 1'b0;
    endfunction

    // Append one symbol on the right and work out the word it produces
    function automatic window_result_t slide_window(input logic [SYM_W-1:0] raw,
                                                    input logic last);
        window_result_t res;
        int unsigned    s;
        int unsigned    span;
        int unsigned    drop;
        s = raw % ALPHABET;
        if (right_edge >= MAX_LEN)
        begin
            // string too long: ignore the symbol, only flag it
            overflow_flag = 1'b1;
        end
        else
        begin
            string_ring[right_edge] = SYM_W'(s);
            symbol_tally[s] += 1;
            if (symbol_tally[s] > peak_count)
                peak_count = symbol_tally[s];
            span = right_edge - left_edge + 1;
            if (span > peak_count + replace_budget)
            begin
                // shrink from the left and rescan for the new peak
                drop = string_ring[left_edge] % ALPHABET;
                if (symbol_tally[drop] > 0)
                    symbol_tally[drop] -= 1;
                peak_count = 0;
                foreach (symbol_tally[i])
                    if (symbol_tally[i] > peak_count)
                        peak_count = symbol_tally[i];
                left_edge += 1;
            end
            else if (span > best_span)
            begin
                best_span = span;
            end
            right_edge += 1;
        end
        res.best_length   = FIELD_W'(best_span);
        res.end_of_string = last;
        res.too_long      = overflow_flag;
        if (last)
            clear_window();
        return res;
    endfunction

    // Predict on every accepted symbol, compare every accepted result word
    always @(posedge clk or negedge rst_n)
    begin
        window_result_t got;
        window_result_t want;
        if (!rst_n)
        begin
            replace_budget = '0;
            clear_window();
            awaited_q.delete();
            pending <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.best_length   = out_ch.best_length;
                got.end_of_string = out_ch.end_of_string;
                got.too_long      = out_ch.too_long;
                if (awaited_q.size() == 0)
                begin
                    error_total++;
                    $error("result word with no symbol waiting: best_length %0d",
                           got.best_length);
                end
                else
                begin
                    want = awaited_q.pop_front();
                    if (got.best_length !== want.best_length)
                    begin
                        error_total++;
                        $error("best_length: expected %0d, got %0d",
                               want.best_length, got.best_length);
                    end
                    if (got.end_of_string !== want.end_of_string)
                    begin
                        error_total++;
                        $error("end_of_string: expected %0b, got %0b",
                               want.end_of_string, got.end_of_string);
                    end
                    if (got.too_long !== want.too_long)
                    begin
                        error_total++;
                        $error("too_long: expected %0b, got %0b",
                               want.too_long, got.too_long);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                awaited_q.push_back(slide_window(in_ch.symbol, in_ch.last_symbol));
            // a register write takes effect for symbols after this edge
            if (cfg_write)
                replace_budget = cfg_data;
            pending <= awaited_q.size();
        end
    end

endmodule

>>> sim/longest_window_k_replacements_top_tb.sv
module longest_window_k_replacements_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lwkr_pkg::*;

    localparam int unsigned STALL_LIMIT = 5000;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [FIELD_W-1:0] cfg_data;
    int                 failures;
    int                 pending;
    int unsigned        quiet_cycles = 0;
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_stall_pct = 0;
    int unsigned        phase;
    int unsigned        setting;

    lwkr_in_if  in_ch ();
    lwkr_out_if out_ch ();

    longest_window_k_replacements_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    lwkr_checker window_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .failures  (failures),
        .pending   (pending)
    );

    always #5 clk = ~clk;

    // Stall the result channel at random
    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // End the run if no word moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one symbol, idling first at random, and hold until it is taken
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.symbol      <= sym;
        in_ch.last_symbol <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Write the replacement budget
    task automatic set_budget(input logic [FIELD_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Stop sending and wait for every expected word to come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Strings of random length over a few nearby symbols, with stray bytes
    task automatic send_random_strings(input int unsigned total);
        int unsigned      sent;
        int unsigned      len;
        int unsigned      pool;
        int unsigned      k;
        logic [SYM_W-1:0] base;
        logic [SYM_W-1:0] sym;
        sent = 0;
        while (sent < total)
        begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
            // cut the final string short so the total stays as asked
            if (len > total - sent)
                len = total - sent;
            pool = $urandom_range(1, 4);
            base = SYM_W'($urandom);
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(99) < 8)
                    sym = SYM_W'($urandom);
                else
                    sym = base + SYM_W'($urandom_range(0, pool - 1));
                send_symbol(sym, k == len - 1);
            end
            sent += len;
        end
    endtask

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_write         = 1'b0;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.symbol      = '0;
        in_ch.last_symbol = 1'b0;
        out_ch.ready      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No replacements: single-symbol string, then extremes of the byte
        set_budget('0);
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'hFF, 1'b1);
        drain_results();

        // One replacement over alternating bit patterns
        set_budget(FIELD_W'(1));
        send_symbol(8'h55, 1'b0);
        send_symbol(8'hAA, 1'b0);
        send_symbol(8'h55, 1'b0);
        send_symbol(8'h55, 1'b0);
        send_symbol(8'hAA, 1'b0);
        send_symbol(8'hAA, 1'b0);
        send_symbol(8'h55, 1'b0);
        send_symbol(8'h0F, 1'b1);
        drain_results();

        // Two replacements, window shrinks after the run of ones
        set_budget(FIELD_W'(2));
        send_symbol(8'h01, 1'b0);
        send_symbol(8'h02, 1'b0);
        send_symbol(8'h03, 1'b0);
        send_symbol(8'h01, 1'b0);
        send_symbol(8'h01, 1'b0);
        send_symbol(8'hF0, 1'b1);
        drain_results();

        // Random strings under each idling pattern and several budgets
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 61;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 61;
                end
                default:
                begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 32;
                end
            endcase
            for (setting = 0; setting < 4; setting++)
            begin
                case (setting)
                    0: set_budget('0);
                    1: set_budget(FIELD_W'($urandom_range(1, 3)));
                    2: set_budget(FIELD_W'($urandom_range(4, 12)));
                    default: set_budget(phase[0] ? FIELD_W'(4096) : FIELD_W'(8191));
                endcase
                send_random_strings(38);
                drain_results();
            end
        end

        repeat (30) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
